// File: rtl/core/lpl_pkg.sv
// shared types and constants of the lookahead peak limiter
`default_nettype none
package lpl_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int GAIN_W     = 17;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_DRIVE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIX       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO    = 3'd5;

  localparam logic [15:0] DRIVE_RST     = 16'd4096;
  localparam logic [15:0] CEILING_RST   = 16'd32768;
  localparam logic [15:0] RELEASE_RST   = 16'd65000;
  localparam logic [8:0]  LOOKAHEAD_RST = 9'd240;
  localparam logic [15:0] MIX_RST       = 16'd32768;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_PEAK,
    ST_DIV_INIT,
    ST_DIV,
    ST_GAIN1,
    ST_GAIN2,
    ST_DRIVE,
    ST_WET,
    ST_DIFF,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

// File: rtl/core/lpl_if.sv
// stream and configuration interfaces of the lookahead peak limiter
`default_nettype none
interface lpl_in_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  modport source (output valid, left_in, right_in, input ready);
  modport sink (input valid, left_in, right_in, output ready);
endinterface

interface lpl_out_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic [16:0]                   current_gain;
  modport source (output valid, left_out, right_out, current_gain, input ready);
  modport sink (input valid, left_out, right_out, current_gain, output ready);
endinterface

interface lpl_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/lookahead_peak_limiter.sv
// lookahead peak limiter: delay rings, gain division, release and mix
// steps: ring read, peak product, divider, gain, drive, wet, difference, output; the divider
// is cut short when the target caps at unity, and a new frame is taken only in idle, after the
// previous result is registered; a result waiting in the output register stalls the next frame
// only at its final step. reset: synchronous, active low; a clearing pass then zeroes
// the rings, input is not taken during it, configuration writes are taken always
`default_nettype none
module lookahead_peak_limiter import lpl_pkg::*; #(
  parameter int RING_DEPTH  = 512,
  parameter int AUDIO_DELAY = 480,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic clk,
  input  wire logic rst_n,
  lpl_in_if.sink    in_if,
  lpl_out_if.source out_if,
  lpl_cfg_if.sink   cfg_if
);

  localparam int SB     = SAMPLE_BITS;
  localparam int AW     = $clog2(RING_DEPTH);
  localparam int PW     = SB - 1;
  localparam int BACK   = AUDIO_DELAY % RING_DEPTH;
  localparam int LAMAX  = AUDIO_DELAY - 1;
  localparam int XW     = $clog2(RING_DEPTH + AUDIO_DELAY);
  localparam int RQ     = (RING_DEPTH + AUDIO_DELAY - 1) / RING_DEPTH;
  localparam int RSTEPS = $clog2(RQ + 1);
  localparam int DW     = SB + 32;
  localparam int NW     = SB + 28;
  localparam int QW     = PW + 16;
  localparam int MW     = SB + 32;
  localparam int WMW    = SB + 4;
  localparam int DFW    = SB + 2;
  localparam int MXW    = SB + 18;

  localparam logic signed [SB+3:0] SAT_HI = (SB+4)'((longint'(1) << (SB - 1)) - 1);
  localparam logic signed [SB+3:0] SAT_LO = ~SAT_HI;

  function automatic logic [SB-1:0] mag_f(input logic [SB-1:0] x);
    return x[SB-1] ? (~x + 1'b1) : x;
  endfunction

  // configuration registers
  logic [15:0] drive_r, ceil_r, rel_r, mix_r;
  logic [8:0]  look_r;
  logic        stereo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r  <= DRIVE_RST;
      ceil_r   <= CEILING_RST;
      rel_r    <= RELEASE_RST;
      look_r   <= LOOKAHEAD_RST;
      mix_r    <= MIX_RST;
      stereo_r <= 1'b1;
    end else if (cfg_if.valid && cfg_if.ready) begin
      unique case (cfg_if.index)
        REG_DRIVE:     drive_r  <= cfg_if.data;
        REG_CEILING:   ceil_r   <= cfg_if.data;
        REG_RELEASE:   rel_r    <= cfg_if.data;
        REG_LOOKAHEAD: look_r   <= cfg_if.data[8:0];
        REG_MIX:       mix_r    <= cfg_if.data;
        REG_STEREO:    stereo_r <= cfg_if.data[0];
        default: ;
      endcase
    end
  end

  state_t state_r, state_nxt;
  logic [AW-1:0] clr_r, wp_r;
  logic [4:0]    cnt_r;
  logic          out_valid_r;
  logic          accept, clearing, out_free, div_last;

  assign accept   = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;
  assign div_last = (cnt_r == 5'd0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:    if (clr_r == AW'(RING_DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:     if (accept) state_nxt = ST_READ;
      ST_READ:     state_nxt = ST_PEAK;
      ST_PEAK:     state_nxt = ST_DIV_INIT;
      ST_DIV_INIT: state_nxt = ST_DIV;
      ST_DIV:      if (div_last) state_nxt = ST_GAIN1;
      ST_GAIN1:    state_nxt = ST_GAIN2;
      ST_GAIN2:    state_nxt = ST_DRIVE;
      ST_DRIVE:    state_nxt = ST_WET;
      ST_WET:      state_nxt = ST_DIFF;
      ST_DIFF:     state_nxt = ST_OUT;
      ST_OUT:      if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    in_if.ready  = (state_r == ST_IDLE);
    cfg_if.ready = 1'b1;
    clearing     = (state_r == ST_CLEAR);
  end

  // ring memories
  logic signed [SB-1:0] lmem [RING_DEPTH];
  logic signed [SB-1:0] rmem [RING_DEPTH];
  logic [PW-1:0]        pmem [RING_DEPTH];
  logic signed [SB-1:0] l_rd, r_rd;
  logic [PW-1:0]        p_rd;
  logic [AW-1:0]        waddr, aread, dread;
  logic signed [SB-1:0] l_wd, r_wd;
  logic [PW-1:0]        p_wd;
  logic                 we_l, we_r;
  logic [SB-1:0]        ml, mr, mx;
  logic [XW-1:0]        la, xsum;

  always_comb begin
    ml = mag_f(in_if.left_in);
    mr = mag_f(in_if.right_in);
    mx = (stereo_r && (mr > ml)) ? mr : ml;
    p_wd = mx[SB-1] ? {PW{1'b1}} : mx[PW-1:0];
    if (clearing) p_wd = '0;
    l_wd  = clearing ? '0 : in_if.left_in;
    r_wd  = clearing ? '0 : in_if.right_in;
    waddr = clearing ? clr_r : wp_r;
    we_l  = clearing || accept;
    we_r  = clearing || (accept && stereo_r);
  end

  // read taps: audio a fixed delay back, detector lookahead frames ahead of it
  always_comb begin
    if (wp_r >= AW'(BACK)) aread = wp_r - AW'(BACK);
    else aread = AW'(32'(wp_r) + 32'(RING_DEPTH - BACK));
    if (32'(look_r) > 32'(LAMAX)) la = XW'(LAMAX);
    else if (look_r == 9'd0) la = XW'(1);
    else la = XW'(look_r);
    xsum = XW'(aread) + la;
    for (int k = RSTEPS - 1; k >= 0; k--) begin
      if (xsum >= XW'(RING_DEPTH << k)) xsum = xsum - XW'(RING_DEPTH << k);
    end
    dread = xsum[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (we_l) begin
      lmem[waddr] <= l_wd;
      pmem[waddr] <= p_wd;
    end
    if (we_r) rmem[waddr] <= r_wd;
    l_rd <= lmem[aread];
    r_rd <= rmem[aread];
    p_rd <= pmem[dread];
  end

  // datapath
  logic [QW-1:0]        prod_r;
  logic [DW-1:0]        rem_r, dsh_r;
  logic [GAIN_W-1:0]    q_r, tg_r, gain_r, tg_c;
  logic                 dec_r;
  logic [32:0]          pa_r;
  logic [33:0]          pb_r;
  logic [31:0]          dg_r;
  logic [MW-1:0]        wprod_r [2];
  logic [MXW-1:0]       mprod_r [2];
  logic                 dneg_r [2];
  logic [QW-1:0]        dv;
  logic [NW-1:0]        num;
  logic                 qbit;
  logic [34:0]          rsum;
  logic [18:0]          rsh;
  logic [GAIN_W-1:0]    g_new;
  logic signed [SB-1:0] dry [2];
  logic signed [SB-1:0] res [2];

  always_comb begin
    dv   = (prod_r == '0) ? QW'(1) : prod_r;
    num  = NW'(ceil_r) << (SB + 12);
    qbit = (rem_r >= dsh_r);
    tg_c = (q_r > UNITY_GAIN) ? UNITY_GAIN : q_r;
    rsum = 35'(pa_r) + 35'(pb_r) + 35'd32768;
    rsh  = rsum[34:16];
    if (dec_r) g_new = tg_r;
    else if (rsh > 19'(UNITY_GAIN)) g_new = UNITY_GAIN;
    else g_new = rsh[GAIN_W-1:0];
    dry[0] = l_rd;
    dry[1] = r_rd;
  end

  // final rounding of the mix and saturation
  always_comb begin
    logic [SB+2:0]        t;
    logic signed [SB+3:0] s, m;
    for (int c = 0; c < 2; c++) begin
      t = (SB+3)'((mprod_r[c] + MXW'(1 << 14)) >> 15);
      s = dneg_r[c] ? -$signed({1'b0, t}) : $signed({1'b0, t});
      m = (SB+4)'(dry[c]) + s;
      if (m > SAT_HI) res[c] = SAT_HI[SB-1:0];
      else if (m < SAT_LO) res[c] = SAT_LO[SB-1:0];
      else res[c] = m[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    logic [MW:0]          wr;
    logic [WMW-1:0]       wm, cl;
    logic signed [DFW-1:0] wet, dif;
    logic [DFW-1:0]       dm;
    unique case (state_r)
      ST_PEAK: prod_r <= QW'(p_rd) * QW'(drive_r);
      ST_DIV_INIT: begin
        if (DW'(num) >= (DW'(dv) << 17)) begin
          q_r   <= UNITY_GAIN;
          cnt_r <= 5'd0;
          dsh_r <= '1;
          rem_r <= '0;
        end else begin
          q_r   <= '0;
          cnt_r <= 5'd16;
          dsh_r <= DW'(dv) << 16;
          rem_r <= DW'(num);
        end
      end
      ST_DIV: begin
        cnt_r <= cnt_r - 5'd1;
        dsh_r <= dsh_r >> 1;
        if (!(q_r == UNITY_GAIN && dsh_r == '1)) begin
          q_r <= {q_r[GAIN_W-2:0], qbit};
          if (qbit) rem_r <= rem_r - dsh_r;
        end
      end
      ST_GAIN1: begin
        tg_r  <= tg_c;
        dec_r <= tg_c < gain_r;
        pa_r  <= 33'(rel_r) * 33'(gain_r);
        pb_r  <= 34'(UNITY_GAIN - 17'(rel_r)) * 34'(tg_c);
      end
      ST_DRIVE: dg_r <= 32'(33'(drive_r) * 33'(gain_r));
      ST_WET: begin
        for (int c = 0; c < 2; c++) begin
          wprod_r[c] <= MW'(mag_f(dry[c])) * MW'(dg_r);
        end
      end
      ST_DIFF: begin
        cl = WMW'(ceil_r) << (SB - 16);
        for (int c = 0; c < 2; c++) begin
          wr  = ((MW+1)'(wprod_r[c]) + (MW+1)'(1 << 27)) >> 28;
          wm  = wr[WMW-1:0];
          if (wm > cl) wm = cl;
          wet = dry[c][SB-1] ? -$signed(DFW'(wm)) : $signed(DFW'(wm));
          dif = wet - DFW'(dry[c]);
          dm  = dif[DFW-1] ? DFW'(-dif) : DFW'(dif);
          mprod_r[c] <= MXW'(dm) * MXW'(mix_r);
          dneg_r[c]  <= dif[DFW-1];
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      wp_r        <= '0;
      gain_r      <= UNITY_GAIN;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_r <= clr_r + 1'b1;
      if (state_r == ST_GAIN2) gain_r <= g_new;
      if (out_valid_r && out_if.ready) out_valid_r <= 1'b0;
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
        wp_r <= (wp_r == AW'(RING_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_if.left_out     <= res[0];
      out_if.right_out    <= stereo_r ? res[1] : '0;
      out_if.current_gain <= gain_r;
    end
  end

  assign out_if.valid = out_valid_r;

`ifndef SYNTHESIS
  a_gain_cap: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r <= UNITY_GAIN) else $error("limiter gain above unity");
  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_READ) else $error("transfer not followed by ring read");
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |=> state_r == ST_DIV || state_r == ST_GAIN1)
    else $error("divider left early");
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_if.ready) else $error("input taken during clearing pass");
`endif

endmodule
`default_nettype wire

// File: sim/tb_lookahead_peak_limiter.sv
// self-checking testbench of the lookahead peak limiter: directed table, register extremes, then random frames
`timescale 1ns / 100ps
module tb_lookahead_peak_limiter import lpl_pkg::*;;

  localparam int RING_DEPTH  = 512;
  localparam int AUDIO_DELAY = 480;
  localparam int SB          = 24;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic signed [SB-1:0] left_s;
    logic signed [SB-1:0] right_s;
    logic [16:0]          gain;
  } frame_result_t;

  typedef struct {
    logic signed [SB-1:0] left_s;
    logic signed [SB-1:0] right_s;
    bit                   has_gold;
    frame_result_t        gold;
  } frame_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  lpl_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
  lpl_out_if #(.SAMPLE_BITS(SB)) out_ch ();
  lpl_cfg_if                     cfg_ch ();

  lookahead_peak_limiter #(
    .RING_DEPTH(RING_DEPTH), .AUDIO_DELAY(AUDIO_DELAY), .SAMPLE_BITS(SB)
  ) dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source),
    .cfg_if(cfg_ch.sink)
  );

  // predictor state
  longint        lim_left_ring [RING_DEPTH];
  longint        lim_right_ring [RING_DEPTH];
  longint        lim_peak_ring [RING_DEPTH];
  int            lim_wp;
  longint        lim_gain;
  longint        r_drive, r_ceiling, r_release, r_look, r_mix, r_stereo;
  frame_result_t pending_results[$];
  frame_row_t    frame_rows[$];

  int  errors = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  recv_hold = 1'b0;
  bit  rows_done = 1'b0;

  function automatic longint mag_of(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint round_scale(longint x, longint factor, int sh);
    longint r;
    r = (mag_of(x) * factor + (longint'(1) << (sh - 1))) >>> sh;
    return x < 0 ? -r : r;
  endfunction

  function automatic longint sat_sample(longint x);
    longint hi;
    hi = (longint'(1) << (SB - 1)) - 1;
    return x > hi ? hi : (x < -hi - 1 ? -hi - 1 : x);
  endfunction

  task automatic predict_frame(input logic signed [SB-1:0] li, input logic signed [SB-1:0] ri);
    longint l, r, peak, la, dback, aread, dread, prod, target, g, clampv;
    longint dry, wet, mixed;
    longint res[2];
    frame_result_t e;
    l = li;
    r = ri;
    peak = mag_of(l);
    lim_left_ring[lim_wp] = l;
    if (r_stereo != 0) begin
      lim_right_ring[lim_wp] = r;
      if (mag_of(r) > peak) peak = mag_of(r);
    end
    if (peak > (longint'(1) << (SB - 1)) - 1) peak = (longint'(1) << (SB - 1)) - 1;
    lim_peak_ring[lim_wp] = peak;
    la = r_look;
    if (la > AUDIO_DELAY - 1) la = AUDIO_DELAY - 1;
    if (la < 1) la = 1;
    dback = (AUDIO_DELAY - la) % RING_DEPTH;
    aread = (lim_wp + RING_DEPTH - (AUDIO_DELAY % RING_DEPTH)) % RING_DEPTH;
    dread = (lim_wp + RING_DEPTH - dback) % RING_DEPTH;
    prod = lim_peak_ring[dread] * r_drive;
    if (prod == 0) prod = 1;
    target = (r_ceiling << (SB + 12)) / prod;
    if (target > 65536) target = 65536;
    g = lim_gain;
    if (target < g) g = target;
    else g = (r_release * g + (65536 - r_release) * target + 32768) >>> 16;
    if (g > 65536) g = 65536;
    lim_gain = g;
    clampv = r_ceiling << (SB - 16);
    for (int ch = 0; ch < 2; ch++) begin
      if (ch == 1 && r_stereo == 0) begin
        res[1] = 0;
      end else begin
        dry = ch == 0 ? lim_left_ring[aread] : lim_right_ring[aread];
        wet = round_scale(dry, r_drive * g, 28);
        if (wet > clampv) wet = clampv;
        if (wet < -clampv) wet = -clampv;
        mixed = dry + round_scale(wet - dry, r_mix, 15);
        res[ch] = sat_sample(mixed);
      end
    end
    e.left_s  = res[0][SB-1:0];
    e.right_s = res[1][SB-1:0];
    e.gain    = g[16:0];
    pending_results.push_back(e);
    lim_wp = (lim_wp + 1) % RING_DEPTH;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_DRIVE:     r_drive   = val;
      REG_CEILING:   r_ceiling = val;
      REG_RELEASE:   r_release = val;
      REG_LOOKAHEAD: r_look    = val[8:0];
      REG_MIX:       r_mix     = val;
      REG_STEREO:    r_stereo  = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // valid stays up between back to back frames and drops only while idling or draining results
  task automatic send_frame(input logic signed [SB-1:0] li, input logic signed [SB-1:0] ri);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.left_in  <= li;
    in_ch.right_in <= ri;
    do @(posedge clk); while (!in_ch.ready);
    predict_frame(li, ri);
    @(negedge clk);
  endtask

  function automatic logic signed [SB-1:0] rand_sample();
    case ($urandom_range(5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return SB'($signed($urandom_range(2000)) - 1000);
      default: return SB'($urandom);
    endcase
  endfunction

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 3) send_frame(rand_sample(), rand_sample());
      else send_frame(SB'($signed($urandom_range(400000)) - 200000),
                      SB'($signed($urandom_range(400000)) - 200000));
    end
  endtask

  // result checker
  always @(posedge clk) begin
    frame_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_ch.left_out !== e.left_s) begin
          $error("left_out expected %0d got %0d", e.left_s, out_ch.left_out);
          errors++;
        end
        if (out_ch.right_out !== e.right_s) begin
          $error("right_out expected %0d got %0d", e.right_s, out_ch.right_out);
          errors++;
        end
        if (out_ch.current_gain !== e.gain) begin
          $error("current_gain expected %0d got %0d", e.gain, out_ch.current_gain);
          errors++;
        end
      end
    end
  end

  // directed rows with gold values checked on top of the predictor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready && frame_rows.size() != 0) begin
      frame_row_t row;
      row = frame_rows.pop_front();
      if (row.has_gold && out_ch.current_gain !== row.gold.gain) begin
        $error("current_gain expected %0d got %0d", row.gold.gain, out_ch.current_gain);
        errors++;
      end
      if (row.has_gold && out_ch.left_out !== row.gold.left_s) begin
        $error("left_out expected %0d got %0d", row.gold.left_s, out_ch.left_out);
        errors++;
      end
    end
  end

  // receiver ready, with random idling and a long hold-off
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic hold_receiver(input int cycles);
    recv_hold = 1'b1;
    repeat (cycles) @(posedge clk);
    recv_hold = 1'b0;
  endtask

  longint cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[lookahead_peak_limiter] ERROR");
      $finish;
    end
  end

  task automatic add_row(input logic signed [SB-1:0] li, input logic signed [SB-1:0] ri,
                         input bit gold_on, input frame_result_t g);
    frame_row_t row;
    row.left_s = li;
    row.right_s = ri;
    row.has_gold = gold_on;
    row.gold = g;
    frame_rows.push_back(row);
  endtask

  initial begin
    frame_row_t table_rows[$];
    frame_result_t z;
    in_ch.valid = 1'b0;
    in_ch.left_in = '0;
    in_ch.right_in = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      lim_left_ring[i] = 0;
      lim_right_ring[i] = 0;
      lim_peak_ring[i] = 0;
    end
    lim_wp = 0;
    lim_gain = 65536;
    r_drive = DRIVE_RST;
    r_ceiling = CEILING_RST;
    r_release = RELEASE_RST;
    r_look = LOOKAHEAD_RST;
    r_mix = MIX_RST;
    r_stereo = 1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: rings are zero, so the first outputs are silent at unity gain
    z.left_s = '0;
    z.right_s = '0;
    z.gain = UNITY_GAIN;
    add_row(24'sh7FFFFF, 24'sh800000, 1'b1, z);
    add_row(24'sh800000, 24'sh7FFFFF, 1'b1, z);
    add_row('0, '0, 1'b1, z);
    add_row(24'sh000001, 24'shFFFFFF, 1'b1, z);
    for (int i = 0; i < 6; i++) add_row(rand_sample(), rand_sample(), 1'b0, z);
    table_rows = frame_rows;
    foreach (table_rows[i]) send_frame(table_rows[i].left_s, table_rows[i].right_s);
    drain_results();

    // extremes of the registers, lookahead out of range, mono, zero ceiling
    write_reg(REG_LOOKAHEAD, 16'd0);
    write_reg(REG_DRIVE, 16'hFFFF);
    write_reg(REG_STEREO, 16'd0);
    for (int i = 0; i < 8; i++) send_frame(rand_sample(), rand_sample());
    drain_results();
    write_reg(REG_LOOKAHEAD, 16'd511);
    write_reg(REG_CEILING, 16'd0);
    write_reg(REG_MIX, 16'hFFFF);
    write_reg(REG_RELEASE, 16'd0);
    write_reg(3'd7, 16'h1234);
    for (int i = 0; i < 6; i++) send_frame(rand_sample(), rand_sample());
    drain_results();

    // random phases through several settings
    send_idle_pct = 20;
    recv_idle_pct = 77;
    write_reg(REG_STEREO, 16'd1);
    write_reg(REG_CEILING, 16'd8000);
    write_reg(REG_DRIVE, 16'd16384);
    write_reg(REG_MIX, 16'd32768);
    write_reg(REG_RELEASE, 16'd60000);
    write_reg(REG_LOOKAHEAD, 16'd4);
    fork
      hold_receiver(600);
    join_none
    random_phase(250);
    drain_results();

    send_idle_pct = 77;
    recv_idle_pct = 20;
    write_reg(REG_CEILING, 16'd1);
    write_reg(REG_DRIVE, 16'd0);
    write_reg(REG_MIX, 16'd16384);
    write_reg(REG_LOOKAHEAD, 16'd479);
    write_reg(REG_RELEASE, 16'd65535);
    random_phase(250);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_CEILING, 16'd32768);
    write_reg(REG_DRIVE, 16'($urandom_range(65535)));
    write_reg(REG_MIX, 16'd0);
    write_reg(REG_LOOKAHEAD, 16'($urandom_range(479, 1)));
    write_reg(REG_STEREO, 16'($urandom_range(1)));
    random_phase(125);
    drain_results();
    write_reg(REG_MIX, 16'd32768);
    write_reg(REG_DRIVE, 16'd20000);
    write_reg(REG_CEILING, 16'd16384);
    random_phase(125);
    drain_results();

    if (errors == 0 && pending_results.size() == 0) begin
      $display("[lookahead_peak_limiter] OK");
    end else begin
      $display("[lookahead_peak_limiter] ERROR");
    end
    $finish;
  end

endmodule

// File: lookahead_peak_limiter.f
rtl/core/lpl_pkg.sv
rtl/core/lpl_if.sv
rtl/core/lookahead_peak_limiter.sv
sim/tb_lookahead_peak_limiter.sv
